// File: src/maze_backtracker_step_top_defines.svh
// assertion helpers for the maze backtracker step block
`ifndef MAZE_BACKTRACKER_STEP_TOP_DEFINES_SVH
`define MAZE_BACKTRACKER_STEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mbs_pkg.sv
package mbs_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam logic [6:0] SIDE_RESET = 7'd16;

  // event codes
  localparam logic [1:0] EV_CARVE   = 2'd0;
  localparam logic [1:0] EV_BACK    = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;
  localparam logic [1:0] EV_RESTART = 2'd3;

  // neighbour order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_DEC
  } state_t;

  // clamp side to 2..mx
  function automatic logic [6:0] side_sat(logic [6:0] v, int unsigned mx);
    if (v < 7'd2) begin
      return 7'd2;
    end
    if (32'(v) > mx) begin
      return 7'(mx);
    end
    return v;
  endfunction

  // r mod c for c in 1..4; mod 3 by folding base-4 digits
  function automatic logic [1:0] mod_cnt(logic [7:0] r, logic [2:0] c);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] s3;
    logic [1:0] res;
    s1 = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    s3 = s2[1:0] + 2'(s2[2]);
    case (c)
      3'd2: begin
        res = {1'b0, r[0]};
      end
      3'd3: begin
        res = (s3 == 2'd3) ? 2'd0 : s3;
      end
      3'd4: begin
        res = r[1:0];
      end
      default: begin
        res = 2'd0;
      end
    endcase
    return res;
  endfunction

endpackage

// File: src/mbs_ram.sv
module mbs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/maze_backtracker_step_top.sv
// maze backtracker step: one step of a randomised depth-first maze walk per transfer
// input channel: in_tdata[7:0] random draw, in_tuser requests a restart of the walk
// result channel: one result per input transfer; out_tuser is the event code
//   (carved, backtracked, already finished, restarted), out_tdata holds the
//   removed wall, the current cell after the step and the done flag
// cfg_wr_en/cfg_wr_data set the grid side (clamped to 2..MAX_SIDE) and restart the walk
// a walking step runs through the transfer, the visited-map read states RD0 and RD1
//   (four neighbour bits through two map copies, two per cycle) and a decide state
//   that writes back map and stack on a carve; the result is registered in that state
// a restart transfer skips the map reads and gives its result from the decide state,
//   then the map is cleared one entry a cycle, all 4096 entries by default, in_tready low
// after reset the same clearing pass runs before the first transfer is taken
// a result waiting in the output register does not block the next transfer; that
//   item holds in its decide cycle until the output register is free
module maze_backtracker_step_top #(
  parameter int MAX_SIDE = mbs_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // random_value [7:0]
  input  logic [7:0]  in_tdata,
  // restart [0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // wall_axis [0], wall_row [7:1], wall_col [13:8], cell_x [19:14], cell_y [25:20],
  // done_res [26], zero fill [31:27]
  output logic [31:0] out_tdata,
  // event_kind [1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  // widths derived from the largest side
  localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int CW1   = CW + 1;
  localparam int CMPW  = (CW1 > 8) ? CW1 : 8;
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int SW    = 2 * CW;
  localparam int DONE_BIT = 26;

  mbs_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [6:0]    side_r, side_nxt;
  logic [DW-1:0] ul_init_r, ul_init_nxt;
  logic [DW-1:0] unvisited_r, unvisited_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] x_r, x_nxt;
  logic [CW-1:0] y_r, y_nxt;

  // latched item and the first two neighbour bits
  logic [7:0] rnd_r, rnd_nxt;
  logic       rst_req_r, rst_req_nxt;
  logic [1:0] vis01_r, vis01_nxt;

  // output register
  logic       out_tvalid_r, out_tvalid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic       out_axis_r, out_axis_nxt;
  logic [6:0] out_row_r, out_row_nxt;
  logic [5:0] out_col_r, out_col_nxt;
  logic [5:0] out_x_r, out_x_nxt;
  logic [5:0] out_y_r, out_y_nxt;
  logic       out_done_r, out_done_nxt;

  // side and walk size for reset or a register write
  logic [6:0]    side_new;
  logic [13:0]   side_sq;
  logic [DW-1:0] ul_new;

  // neighbour geometry
  logic [CW-1:0] nx [4];
  logic [CW-1:0] ny [4];
  logic [3:0]    in_grid;
  logic [3:0]    unv;
  logic [2:0]    unv_cnt;
  logic [1:0]    pick;
  logic [1:0]    sel;

  // map and stack ports
  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;
  logic [AW-1:0] vis_raddr_a, vis_raddr_b;
  logic          vis_q_a, vis_q_b;
  logic          stk_we;
  logic [SW-1:0] stk_q;
  logic [DW-1:0] depth_m1;

  logic out_free;
  logic carve_fire;

  function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] cx, logic [CW-1:0] cy);
    return AW'(AW'(cx) * AW'(MAX_SIDE) + AW'(cy));
  endfunction

  assign side_new = mbs_pkg::side_sat(rst_n ? cfg_wr_data : mbs_pkg::SIDE_RESET,
                                      MAX_SIDE);
  assign side_sq  = {7'd0, side_new} * {7'd0, side_new};
  assign ul_new   = DW'(side_sq - 14'd1);

  assign in_tready  = (state_r == mbs_pkg::ST_IDLE);
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_done_r, out_y_r, out_x_r, out_col_r, out_row_r,
                       out_axis_r};

  // neighbours in order up, right, down, left
  always_comb begin
    nx[0] = x_r;
    ny[0] = y_r - CW'(1);
    nx[1] = x_r + CW'(1);
    ny[1] = y_r;
    nx[2] = x_r;
    ny[2] = y_r + CW'(1);
    nx[3] = x_r - CW'(1);
    ny[3] = y_r;
    in_grid[0] = (y_r != '0);
    in_grid[1] = (CMPW'(x_r) + CMPW'(1)) < CMPW'(side_r);
    in_grid[2] = (CMPW'(y_r) + CMPW'(1)) < CMPW'(side_r);
    in_grid[3] = (x_r != '0);
  end

  // two reads per cycle: up/right first, then down/left held through decide
  always_comb begin
    if (state_r == mbs_pkg::ST_RD0) begin
      vis_raddr_a = cell_addr(nx[0], ny[0]);
      vis_raddr_b = cell_addr(nx[1], ny[1]);
    end else begin
      vis_raddr_a = cell_addr(nx[2], ny[2]);
      vis_raddr_b = cell_addr(nx[3], ny[3]);
    end
  end

  assign unv[0] = in_grid[0] && !vis01_r[0];
  assign unv[1] = in_grid[1] && !vis01_r[1];
  assign unv[2] = in_grid[2] && !vis_q_a;
  assign unv[3] = in_grid[3] && !vis_q_b;
  assign unv_cnt = 3'($countones(unv));
  assign pick    = mbs_pkg::mod_cnt(rnd_r, unv_cnt);

  // pick-th unvisited neighbour
  always_comb begin
    logic [1:0] seen;
    seen = 2'd0;
    sel  = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (unv[d]) begin
        if (seen == pick) begin
          sel = 2'(d);
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign depth_m1 = depth_r - DW'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    side_nxt       = side_r;
    ul_init_nxt    = ul_init_r;
    unvisited_nxt  = unvisited_r;
    depth_nxt      = depth_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    rnd_nxt        = rnd_r;
    rst_req_nxt    = rst_req_r;
    vis01_nxt      = vis01_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_axis_nxt   = out_axis_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_done_nxt   = out_done_r;
    vis_we         = 1'b0;
    vis_waddr      = clr_cnt_r;
    vis_wdata      = 1'b0;
    stk_we         = 1'b0;
    carve_fire     = 1'b0;

    case (state_r)
      mbs_pkg::ST_CLR: begin
        // sweep the map, leaving the origin visited
        vis_we    = 1'b1;
        vis_wdata = (clr_cnt_r == '0);
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          state_nxt = mbs_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      mbs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          rnd_nxt     = in_tdata;
          rst_req_nxt = in_tuser;
          state_nxt   = in_tuser ? mbs_pkg::ST_DEC : mbs_pkg::ST_RD0;
        end
      end
      mbs_pkg::ST_RD0: begin
        state_nxt = mbs_pkg::ST_RD1;
      end
      mbs_pkg::ST_RD1: begin
        vis01_nxt = {vis_q_b, vis_q_a};
        state_nxt = mbs_pkg::ST_DEC;
      end
      mbs_pkg::ST_DEC: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_axis_nxt   = 1'b0;
          out_row_nxt    = 7'd0;
          out_col_nxt    = 6'd0;
          state_nxt      = mbs_pkg::ST_IDLE;
          if (rst_req_r) begin
            out_kind_nxt  = mbs_pkg::EV_RESTART;
            x_nxt         = '0;
            y_nxt         = '0;
            depth_nxt     = '0;
            unvisited_nxt = ul_init_r;
            clr_cnt_nxt   = '0;
            state_nxt     = mbs_pkg::ST_CLR;
          end else if (unvisited_r == '0) begin
            out_kind_nxt = mbs_pkg::EV_DONE;
          end else if (unv_cnt != 3'd0) begin
            out_kind_nxt  = mbs_pkg::EV_CARVE;
            carve_fire    = 1'b1;
            x_nxt         = nx[sel];
            y_nxt         = ny[sel];
            unvisited_nxt = unvisited_r - DW'(1);
            vis_we        = 1'b1;
            vis_waddr     = cell_addr(nx[sel], ny[sel]);
            vis_wdata     = 1'b1;
            if (depth_r < DW'(CELLS)) begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + DW'(1);
            end
            case (sel)
              mbs_pkg::DIR_UP: begin
                out_axis_nxt = 1'b1;
                out_row_nxt  = 7'(y_r);
                out_col_nxt  = 6'(x_r);
              end
              mbs_pkg::DIR_RIGHT: begin
                out_axis_nxt = 1'b0;
                out_row_nxt  = 7'(CW1'(x_r) + CW1'(1));
                out_col_nxt  = 6'(y_r);
              end
              mbs_pkg::DIR_DOWN: begin
                out_axis_nxt = 1'b1;
                out_row_nxt  = 7'(CW1'(y_r) + CW1'(1));
                out_col_nxt  = 6'(x_r);
              end
              default: begin
                out_axis_nxt = 1'b0;
                out_row_nxt  = 7'(x_r);
                out_col_nxt  = 6'(y_r);
              end
            endcase
          end else begin
            out_kind_nxt = mbs_pkg::EV_BACK;
            if (depth_r != '0) begin
              depth_nxt = depth_m1;
              x_nxt     = stk_q[SW-1:CW];
              y_nxt     = stk_q[CW-1:0];
            end
          end
          out_x_nxt    = 6'(x_nxt);
          out_y_nxt    = 6'(y_nxt);
          out_done_nxt = (unvisited_nxt == '0);
        end
      end
      default: begin
        clr_cnt_nxt = '0;
        state_nxt   = mbs_pkg::ST_CLR;
      end
    endcase

    // a side write restarts the walk and sweeps the map again
    if (cfg_wr_en) begin
      side_nxt      = side_new;
      ul_init_nxt   = ul_new;
      unvisited_nxt = ul_new;
      depth_nxt     = '0;
      x_nxt         = '0;
      y_nxt         = '0;
      clr_cnt_nxt   = '0;
      state_nxt     = mbs_pkg::ST_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mbs_pkg::ST_CLR;
      clr_cnt_r    <= '0;
      side_r       <= side_new;
      ul_init_r    <= ul_new;
      unvisited_r  <= ul_new;
      depth_r      <= '0;
      x_r          <= '0;
      y_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      side_r       <= side_nxt;
      ul_init_r    <= ul_init_nxt;
      unvisited_r  <= unvisited_nxt;
      depth_r      <= depth_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    rst_req_r  <= rst_req_nxt;
    vis01_r    <= vis01_nxt;
    out_kind_r <= out_kind_nxt;
    out_axis_r <= out_axis_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_done_r <= out_done_nxt;
  end

  // two identical copies of the visited map give two reads a cycle
  mbs_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_vis_a (
    .clk     (clk),
    .wr_en   (vis_we),
    .wr_addr (vis_waddr),
    .wr_data (vis_wdata),
    .rd_addr (vis_raddr_a),
    .rd_data (vis_q_a)
  );

  mbs_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_vis_b (
    .clk     (clk),
    .wr_en   (vis_we),
    .wr_addr (vis_waddr),
    .wr_data (vis_wdata),
    .rd_addr (vis_raddr_b),
    .rd_data (vis_q_b)
  );

  // path stack, top of stack read every cycle
  mbs_ram #(
    .WIDTH (SW),
    .DEPTH (CELLS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (depth_r[AW-1:0]),
    .wr_data ({x_r, y_r}),
    .rd_addr (depth_m1[AW-1:0]),
    .rd_data (stk_q)
  );

`include "maze_backtracker_step_top_defines.svh"

  `MBS_ASSERT_NXT(a_step_reads_first, in_tvalid && in_tready && !in_tuser && !cfg_wr_en, state_r == mbs_pkg::ST_RD0, "walking step did not start with map reads")
  `MBS_ASSERT_NXT(a_carve_counts_down, carve_fire && !cfg_wr_en, unvisited_r == $past(unvisited_r) - DW'(1), "carve did not count down unvisited cells")
  `MBS_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DW'(CELLS), "stack depth beyond capacity")
  `MBS_ASSERT_IMP(a_done_event_flag, out_tvalid && (out_tuser == mbs_pkg::EV_DONE), out_tdata[DONE_BIT], "finished event without done flag")

endmodule
